/* sv/srsp_pkg.sv */
// Shared types and constants for the stroke record stream parser.
`timescale 1ns / 1ps

package srsp_pkg;

	// Parse phases; the numbering matches the token kind of the field that the phase reads.
	typedef enum logic [4:0] {
		PH_VERSION  = 5'd0,
		PH_STROKES  = 5'd1,
		PH_ERASER   = 5'd2,
		PH_COLOR    = 5'd3,
		PH_WIDTH    = 5'd4,
		PH_ALPHA    = 5'd5,
		PH_NPOINTS  = 5'd6,
		PH_POINT    = 5'd7,
		PH_NIDX     = 5'd13,
		PH_INDEX    = 5'd14,
		PH_ALPHAMOD = 5'd15,
		PH_TOOLLEN  = 5'd16,
		PH_TOOLBYTE = 5'd17,
		PH_NCIRCLES = 5'd18,
		PH_CIRCLE   = 5'd19,
		PH_IDLE     = 5'd31
	} phase_t;

	typedef enum logic [2:0] {
		ERR_SHORT   = 3'd0,
		ERR_VERSION = 3'd1,
		ERR_STROKES = 3'd2,
		ERR_POINTS  = 3'd3,
		ERR_INDICES = 3'd4,
		ERR_TOOLLEN = 3'd5,
		ERR_CIRCLES = 3'd6,
		ERR_TRUNC   = 3'd7
	} err_t;

	typedef enum logic [2:0] {
		CFG_MAX_STROKES = 3'd0,
		CFG_MAX_POINTS  = 3'd1,
		CFG_MAX_INDICES = 3'd2,
		CFG_MAX_TOOLLEN = 3'd3,
		CFG_MAX_CIRCLES = 3'd4
	} cfg_idx_t;

	localparam logic [4:0] KIND_POINT_X  = 5'd7;
	localparam logic [4:0] KIND_CIRCLE_X = 5'd19;
	localparam logic [4:0] KIND_ERROR    = 5'd22;

	localparam logic [19:0] RST_MAX_STROKES = 20'd100000;
	localparam logic [19:0] RST_MAX_POINTS  = 20'd1000000;
	localparam logic [19:0] RST_MAX_INDICES = 20'd1000000;
	localparam logic [15:0] RST_MAX_TOOLLEN = 16'd1024;
	localparam logic [19:0] RST_MAX_CIRCLES = 20'd1000000;

	localparam logic [31:0] MIN_PAYLOAD_BYTES = 32'd8;
	localparam logic [2:0]  POINT_WORDS       = 3'd6;
	localparam logic [2:0]  CIRCLE_WORDS      = 3'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_of_payload;
		logic [31:0] payload_bytes;
	} byte_req_t;

	typedef struct packed {
		logic [4:0]  field_kind;
		logic [31:0] field_value;
		logic [19:0] stroke_number;
		logic [19:0] element_number;
		logic [2:0]  error_code;
		logic        payload_done;
	} token_t;

endpackage

/* sv/stroke_record_stream_parser.sv */
// Stroke record stream parser: byte-at-a-time field decoder with count checks.
// Output: a byte accepted at an edge puts its token, if any, in the output register
// at that same edge, so the token is visible in the following cycle.
// Throughput: one byte per cycle; byte_stall rises only while a token waits in the
// output register and token_stall holds it.
// Reset: limit registers take their defaults, the parser is idle and ignores bytes
// until a request marked start_of_payload arrives.
`timescale 1ns / 1ps

module stroke_record_stream_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  srsp_pkg::byte_req_t byte_req,
	output logic                token_valid,
	input  logic                token_stall,
	output srsp_pkg::token_t    token,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data
);

	// Limit registers
	logic [19:0] max_strokes_q, max_points_q, max_indices_q, max_circles_q;
	logic [15:0] max_toollen_q;

	// Parser state
	srsp_pkg::phase_t phase_q;
	logic [2:0]  version_q;
	logic [1:0]  bif_q;
	logic [23:0] acc_q;
	logic [19:0] strokes_total_q, stroke_cnt_q, elem_total_q, elem_cnt_q;
	logic [2:0]  sub_q;
	logic [31:0] rem_q;

	// Effective state for this byte (a start request clears the parse)
	srsp_pkg::phase_t cur_phase;
	logic [2:0]  cur_version;
	logic [1:0]  cur_bif;
	logic [23:0] cur_acc;
	logic [19:0] cur_strokes_total, cur_stroke_cnt, cur_elem_total, cur_elem_cnt;
	logic [2:0]  cur_sub;
	logic [31:0] cur_rem;

	srsp_pkg::phase_t nxt_phase;
	logic [2:0]  nxt_version;
	logic [1:0]  nxt_bif;
	logic [23:0] nxt_acc;
	logic [19:0] nxt_strokes_total, nxt_stroke_cnt, nxt_elem_total, nxt_elem_cnt;
	logic [2:0]  nxt_sub;
	logic [31:0] nxt_rem;
	logic        nxt_done;

	logic        accept, start, len_ok, short_err, active;
	logic        width1, complete;
	logic [31:0] v;
	logic [36:0] v_x24;
	logic [35:0] v_x12;
	logic [33:0] v_x4;
	logic        cnt_err;
	srsp_pkg::err_t cnt_code;
	logic        trunc, produced;
	logic [19:0] stroke_inc, elem_inc;
	logic [2:0]  sub_inc;
	logic        stroke_last;
	srsp_pkg::phase_t ph_end_stroke, ph_after_tool, ph_after_alphamod, ph_after_indices;
	srsp_pkg::phase_t pre_phase;
	logic        es_after_tool, es_after_alphamod, es_after_indices;
	srsp_pkg::token_t tok;

	assign accept     = byte_valid & ~byte_stall;
	assign byte_stall = token_valid & token_stall;
	assign cfg_ready  = 1'b1;

	assign start     = byte_req.start_of_payload;
	assign len_ok    = byte_req.payload_bytes >= srsp_pkg::MIN_PAYLOAD_BYTES;
	assign short_err = accept & start & ~len_ok;

	always_comb begin
		if (start) begin
			cur_phase         = len_ok ? srsp_pkg::PH_VERSION : srsp_pkg::PH_IDLE;
			cur_version       = 3'd0;
			cur_bif           = 2'd0;
			cur_acc           = 24'd0;
			cur_strokes_total = 20'd0;
			cur_stroke_cnt    = 20'd0;
			cur_elem_total    = 20'd0;
			cur_elem_cnt      = 20'd0;
			cur_sub           = 3'd0;
			cur_rem           = byte_req.payload_bytes;
		end else begin
			cur_phase         = phase_q;
			cur_version       = version_q;
			cur_bif           = bif_q;
			cur_acc           = acc_q;
			cur_strokes_total = strokes_total_q;
			cur_stroke_cnt    = stroke_cnt_q;
			cur_elem_total    = elem_total_q;
			cur_elem_cnt      = elem_cnt_q;
			cur_sub           = sub_q;
			cur_rem           = rem_q;
		end
	end

	assign active = accept & (cur_phase != srsp_pkg::PH_IDLE);

	assign width1 = (cur_phase == srsp_pkg::PH_ERASER) || (cur_phase == srsp_pkg::PH_ALPHA) ||
		(cur_phase == srsp_pkg::PH_TOOLBYTE);
	assign complete = width1 || (cur_bif == 2'd3);
	assign v = width1 ? {24'd0, byte_req.data_byte} : {byte_req.data_byte, cur_acc};

	// A count n fits the bytes left after this one when k*n <= rem - 1, i.e. k*n < rem.
	assign v_x24 = ({5'd0, v} << 4) + ({5'd0, v} << 3);
	assign v_x12 = ({4'd0, v} << 3) + ({4'd0, v} << 2);
	assign v_x4  = {v, 2'b00};

	always_comb begin
		cnt_err  = 1'b0;
		cnt_code = srsp_pkg::ERR_SHORT;
		case (cur_phase)
			srsp_pkg::PH_VERSION: begin
				cnt_err  = (v < 32'd1) || (v > 32'd4);
				cnt_code = srsp_pkg::ERR_VERSION;
			end
			srsp_pkg::PH_STROKES: begin
				cnt_err  = v > {12'd0, max_strokes_q};
				cnt_code = srsp_pkg::ERR_STROKES;
			end
			srsp_pkg::PH_NPOINTS: begin
				cnt_err  = (v > {12'd0, max_points_q}) || (v_x24 >= {5'd0, cur_rem});
				cnt_code = srsp_pkg::ERR_POINTS;
			end
			srsp_pkg::PH_NIDX: begin
				cnt_err  = (v > {12'd0, max_indices_q}) || (v_x4 >= {2'd0, cur_rem});
				cnt_code = srsp_pkg::ERR_INDICES;
			end
			srsp_pkg::PH_TOOLLEN: begin
				cnt_err  = (v > {16'd0, max_toollen_q}) || (v >= cur_rem);
				cnt_code = srsp_pkg::ERR_TOOLLEN;
			end
			srsp_pkg::PH_NCIRCLES: begin
				cnt_err  = (v > {12'd0, max_circles_q}) || (v_x12 >= {4'd0, cur_rem});
				cnt_code = srsp_pkg::ERR_CIRCLES;
			end
			default: begin
				cnt_err  = 1'b0;
				cnt_code = srsp_pkg::ERR_SHORT;
			end
		endcase
	end

	// Where the parse goes once a stroke's trailing lists are done, by format version.
	assign stroke_inc        = cur_stroke_cnt + 20'd1;
	assign elem_inc          = cur_elem_cnt + 20'd1;
	assign sub_inc           = cur_sub + 3'd1;
	assign stroke_last       = stroke_inc >= cur_strokes_total;
	assign ph_end_stroke     = stroke_last ? srsp_pkg::PH_IDLE : srsp_pkg::PH_ERASER;
	assign es_after_tool     = cur_version < 3'd4;
	assign es_after_alphamod = cur_version < 3'd3;
	assign es_after_indices  = cur_version < 3'd2;
	assign ph_after_tool     = es_after_tool ? ph_end_stroke : srsp_pkg::PH_NCIRCLES;
	assign ph_after_alphamod = es_after_alphamod ? ph_after_tool : srsp_pkg::PH_TOOLLEN;
	assign ph_after_indices  = es_after_indices ? ph_after_alphamod : srsp_pkg::PH_ALPHAMOD;

	// Next state
	always_comb begin
		nxt_phase         = cur_phase;
		nxt_version       = cur_version;
		nxt_bif           = cur_bif;
		nxt_acc           = cur_acc;
		nxt_strokes_total = cur_strokes_total;
		nxt_stroke_cnt    = cur_stroke_cnt;
		nxt_elem_total    = cur_elem_total;
		nxt_elem_cnt      = cur_elem_cnt;
		nxt_sub           = cur_sub;
		nxt_rem           = cur_rem;
		nxt_done          = 1'b0;
		if (active) begin
			nxt_rem = cur_rem - 32'd1;
			if (!complete) begin
				nxt_bif = cur_bif + 2'd1;
				nxt_acc[8*cur_bif +: 8] = byte_req.data_byte;
			end else begin
				nxt_bif = 2'd0;
				nxt_acc = 24'd0;
				if (cnt_err) begin
					nxt_phase = srsp_pkg::PH_IDLE;
				end else begin
					case (cur_phase)
						srsp_pkg::PH_VERSION: begin
							nxt_version = v[2:0];
							nxt_phase   = srsp_pkg::PH_STROKES;
						end
						srsp_pkg::PH_STROKES: begin
							nxt_strokes_total = v[19:0];
							nxt_stroke_cnt    = 20'd0;
							if (v == 32'd0) begin
								nxt_phase = srsp_pkg::PH_IDLE;
								nxt_done  = 1'b1;
							end else begin
								nxt_phase = srsp_pkg::PH_ERASER;
							end
						end
						srsp_pkg::PH_ERASER, srsp_pkg::PH_COLOR, srsp_pkg::PH_WIDTH,
						srsp_pkg::PH_ALPHA: begin
							nxt_phase = srsp_pkg::phase_t'(cur_phase + 5'd1);
						end
						srsp_pkg::PH_NPOINTS: begin
							nxt_elem_total = v[19:0];
							nxt_elem_cnt   = 20'd0;
							if (v == 32'd0) begin
								nxt_phase = srsp_pkg::PH_NIDX;
							end else begin
								nxt_sub   = 3'd0;
								nxt_phase = srsp_pkg::PH_POINT;
							end
						end
						srsp_pkg::PH_POINT: begin
							nxt_sub = sub_inc;
							if (sub_inc >= srsp_pkg::POINT_WORDS) begin
								nxt_sub      = 3'd0;
								nxt_elem_cnt = elem_inc;
								if (elem_inc >= cur_elem_total) begin
									nxt_phase = srsp_pkg::PH_NIDX;
								end
							end
						end
						srsp_pkg::PH_NIDX: begin
							if (v == 32'd0) begin
								nxt_phase = ph_after_indices;
								if (es_after_indices) begin
									nxt_stroke_cnt = stroke_inc;
									nxt_done       = stroke_last;
								end
							end else begin
								nxt_elem_total = v[19:0];
								nxt_elem_cnt   = 20'd0;
								nxt_sub        = 3'd0;
								nxt_phase      = srsp_pkg::PH_INDEX;
							end
						end
						srsp_pkg::PH_INDEX: begin
							nxt_elem_cnt = elem_inc;
							if (elem_inc >= cur_elem_total) begin
								nxt_phase = ph_after_indices;
								if (es_after_indices) begin
									nxt_stroke_cnt = stroke_inc;
									nxt_done       = stroke_last;
								end
							end
						end
						srsp_pkg::PH_ALPHAMOD: begin
							nxt_phase = ph_after_alphamod;
							if (es_after_alphamod) begin
								nxt_stroke_cnt = stroke_inc;
								nxt_done       = stroke_last;
							end
						end
						srsp_pkg::PH_TOOLLEN: begin
							if (v == 32'd0) begin
								nxt_phase = ph_after_tool;
								if (es_after_tool) begin
									nxt_stroke_cnt = stroke_inc;
									nxt_done       = stroke_last;
								end
							end else begin
								nxt_elem_total = v[19:0];
								nxt_elem_cnt   = 20'd0;
								nxt_sub        = 3'd0;
								nxt_phase      = srsp_pkg::PH_TOOLBYTE;
							end
						end
						srsp_pkg::PH_TOOLBYTE: begin
							nxt_elem_cnt = elem_inc;
							if (elem_inc >= cur_elem_total) begin
								nxt_phase = ph_after_tool;
								if (es_after_tool) begin
									nxt_stroke_cnt = stroke_inc;
									nxt_done       = stroke_last;
								end
							end
						end
						srsp_pkg::PH_NCIRCLES: begin
							if (v == 32'd0) begin
								nxt_phase      = ph_end_stroke;
								nxt_stroke_cnt = stroke_inc;
								nxt_done       = stroke_last;
							end else begin
								nxt_elem_total = v[19:0];
								nxt_elem_cnt   = 20'd0;
								nxt_sub        = 3'd0;
								nxt_phase      = srsp_pkg::PH_CIRCLE;
							end
						end
						srsp_pkg::PH_CIRCLE: begin
							nxt_sub = sub_inc;
							if (sub_inc >= srsp_pkg::CIRCLE_WORDS) begin
								nxt_sub      = 3'd0;
								nxt_elem_cnt = elem_inc;
								if (elem_inc >= cur_elem_total) begin
									nxt_phase      = ph_end_stroke;
									nxt_stroke_cnt = stroke_inc;
									nxt_done       = stroke_last;
								end
							end
						end
						default: begin
							nxt_phase = srsp_pkg::PH_IDLE;
						end
					endcase
				end
			end
			// The last payload byte left the parse unfinished.
			if (trunc) begin
				nxt_phase = srsp_pkg::PH_IDLE;
			end
		end
	end

	// Phase before the truncation override, kept separate so trunc does not loop on itself.
	always_comb begin
		pre_phase = cur_phase;
		if (complete) begin
			case (cur_phase)
				srsp_pkg::PH_STROKES:
					pre_phase = (v == 32'd0) ? srsp_pkg::PH_IDLE : srsp_pkg::PH_ERASER;
				srsp_pkg::PH_NIDX:
					pre_phase = (v == 32'd0) ? ph_after_indices : srsp_pkg::PH_INDEX;
				srsp_pkg::PH_INDEX:
					pre_phase = (elem_inc >= cur_elem_total) ? ph_after_indices :
						srsp_pkg::PH_INDEX;
				srsp_pkg::PH_ALPHAMOD:
					pre_phase = ph_after_alphamod;
				srsp_pkg::PH_TOOLLEN:
					pre_phase = (v == 32'd0) ? ph_after_tool : srsp_pkg::PH_TOOLBYTE;
				srsp_pkg::PH_TOOLBYTE:
					pre_phase = (elem_inc >= cur_elem_total) ? ph_after_tool :
						srsp_pkg::PH_TOOLBYTE;
				srsp_pkg::PH_NCIRCLES:
					pre_phase = (v == 32'd0) ? ph_end_stroke : srsp_pkg::PH_CIRCLE;
				srsp_pkg::PH_CIRCLE:
					pre_phase = ((sub_inc >= srsp_pkg::CIRCLE_WORDS) &&
						(elem_inc >= cur_elem_total)) ? ph_end_stroke : srsp_pkg::PH_CIRCLE;
				default:
					pre_phase = srsp_pkg::PH_ERASER;
			endcase
		end
	end

	assign trunc = active && !(complete && cnt_err) && (cur_rem == 32'd1) &&
		(pre_phase != srsp_pkg::PH_IDLE);

	assign produced = short_err | (active & (complete | trunc));

	// Token contents
	always_comb begin
		tok = '0;
		if (short_err) begin
			tok.field_kind = srsp_pkg::KIND_ERROR;
			tok.error_code = srsp_pkg::ERR_SHORT;
		end else if (complete && cnt_err) begin
			tok.field_kind     = srsp_pkg::KIND_ERROR;
			tok.error_code     = cnt_code;
			tok.field_value    = v;
			tok.stroke_number  = cur_stroke_cnt;
			tok.element_number = cur_elem_cnt;
		end else if (trunc) begin
			tok.field_kind     = srsp_pkg::KIND_ERROR;
			tok.error_code     = srsp_pkg::ERR_TRUNC;
			tok.stroke_number  = nxt_stroke_cnt;
			tok.element_number = nxt_elem_cnt;
		end else begin
			tok.field_value   = v;
			tok.stroke_number = (cur_phase == srsp_pkg::PH_STROKES) ? 20'd0 : cur_stroke_cnt;
			tok.payload_done  = nxt_done;
			case (cur_phase)
				srsp_pkg::PH_POINT: begin
					tok.field_kind     = srsp_pkg::KIND_POINT_X + {2'd0, cur_sub};
					tok.element_number = cur_elem_cnt;
				end
				srsp_pkg::PH_CIRCLE: begin
					tok.field_kind     = srsp_pkg::KIND_CIRCLE_X + {2'd0, cur_sub};
					tok.element_number = cur_elem_cnt;
				end
				srsp_pkg::PH_INDEX, srsp_pkg::PH_TOOLBYTE: begin
					tok.field_kind     = cur_phase;
					tok.element_number = cur_elem_cnt;
				end
				default: begin
					tok.field_kind     = cur_phase;
					tok.element_number = 20'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= srsp_pkg::PH_IDLE;
			version_q       <= 3'd0;
			bif_q           <= 2'd0;
			acc_q           <= 24'd0;
			strokes_total_q <= 20'd0;
			stroke_cnt_q    <= 20'd0;
			elem_total_q    <= 20'd0;
			elem_cnt_q      <= 20'd0;
			sub_q           <= 3'd0;
			rem_q           <= 32'd0;
		end else if (accept) begin
			phase_q         <= nxt_phase;
			version_q       <= nxt_version;
			bif_q           <= nxt_bif;
			acc_q           <= nxt_acc;
			strokes_total_q <= nxt_strokes_total;
			stroke_cnt_q    <= nxt_stroke_cnt;
			elem_total_q    <= nxt_elem_total;
			elem_cnt_q      <= nxt_elem_cnt;
			sub_q           <= nxt_sub;
			rem_q           <= nxt_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
		end else if (accept && produced) begin
			token_valid <= 1'b1;
		end else if (!token_stall) begin
			token_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produced) begin
			token <= tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_strokes_q <= srsp_pkg::RST_MAX_STROKES;
			max_points_q  <= srsp_pkg::RST_MAX_POINTS;
			max_indices_q <= srsp_pkg::RST_MAX_INDICES;
			max_toollen_q <= srsp_pkg::RST_MAX_TOOLLEN;
			max_circles_q <= srsp_pkg::RST_MAX_CIRCLES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srsp_pkg::CFG_MAX_STROKES: max_strokes_q <= cfg_data;
				srsp_pkg::CFG_MAX_POINTS:  max_points_q  <= cfg_data;
				srsp_pkg::CFG_MAX_INDICES: max_indices_q <= cfg_data;
				srsp_pkg::CFG_MAX_TOOLLEN: max_toollen_q <= cfg_data[15:0];
				srsp_pkg::CFG_MAX_CIRCLES: max_circles_q <= cfg_data;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// An active parse always has at least one payload byte still to come.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != srsp_pkg::PH_IDLE) |-> (rem_q != 32'd0))
		else $error("parser active with no payload bytes left");

	// Every error token ends the payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && produced && (tok.field_kind == srsp_pkg::KIND_ERROR)) |=>
		(phase_q == srsp_pkg::PH_IDLE))
		else $error("parser still active after an error token");

	// A token marked done never carries an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token.payload_done) |->
		((token.field_kind != srsp_pkg::KIND_ERROR) && (token.error_code == srsp_pkg::ERR_SHORT)))
		else $error("done token carries an error");

	// Word counters inside a point or circle stay below the word count.
	assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == srsp_pkg::PH_POINT) |-> (sub_q < srsp_pkg::POINT_WORDS)) and
		((phase_q == srsp_pkg::PH_CIRCLE) |-> (sub_q < srsp_pkg::CIRCLE_WORDS)))
		else $error("subfield counter out of range");

	// A token waiting under stall is not overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_stall) |=> (token_valid && $stable(token)))
		else $error("stalled token lost");
`endif

endmodule
